### rtl/mtcs_pkg.sv
package mtcs_pkg;

  localparam int DEF_NUM_SLOTS   = 16;
  localparam int DEF_COUNT_WIDTH = 24;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 4;
  localparam int TICK_W  = 24;
  localparam int MODE_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PASS    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 2'd3;

  localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUNNING   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd3;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef struct packed {
    logic shift;
    logic wr_mode;
    logic wr_counts;
  } cell_ctrl_t;

endpackage

### rtl/mtcs_cell.sv
module mtcs_cell #(
  parameter int COUNT_WIDTH = mtcs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtcs_pkg::cell_ctrl_t        ctrl,
  input  logic [mtcs_pkg::MODE_W-1:0] wr_mode,
  input  logic [COUNT_WIDTH-1:0]      wr_count,
  input  logic [mtcs_pkg::MODE_W-1:0] sh_mode,
  input  logic [COUNT_WIDTH-1:0]      sh_rem,
  input  logic [COUNT_WIDTH-1:0]      sh_rel,
  output logic [mtcs_pkg::MODE_W-1:0] mode,
  output logic [COUNT_WIDTH-1:0]      rem,
  output logic [COUNT_WIDTH-1:0]      rel
);
  import mtcs_pkg::*;

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] rel_r, rel_nxt;

  always_comb begin
    mode_nxt = mode_r;
    rem_nxt  = rem_r;
    rel_nxt  = rel_r;
    priority if (ctrl.shift) begin
      mode_nxt = sh_mode;
      rem_nxt  = sh_rem;
      rel_nxt  = sh_rel;
    end else begin
      if (ctrl.wr_mode) begin
        mode_nxt = wr_mode;
      end
      if (ctrl.wr_counts) begin
        rem_nxt = wr_count;
        rel_nxt = wr_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    rel_r <= rel_nxt;
  end

  assign mode = mode_r;
  assign rem  = rem_r;
  assign rel  = rel_r;

endmodule

### rtl/mtcs_slot_proc.sv
module mtcs_slot_proc #(
  parameter int COUNT_WIDTH = mtcs_pkg::DEF_COUNT_WIDTH
) (
  input  logic [mtcs_pkg::MODE_W-1:0] mode_i,
  input  logic [COUNT_WIDTH-1:0]      rem_i,
  input  logic [COUNT_WIDTH-1:0]      rel_i,
  input  logic [COUNT_WIDTH-1:0]      elapsed,
  input  logic [COUNT_WIDTH-1:0]      next_i,
  output logic [mtcs_pkg::MODE_W-1:0] mode_o,
  output logic [COUNT_WIDTH-1:0]      rem_o,
  output logic                        expired,
  output logic [COUNT_WIDTH-1:0]      next_o
);
  import mtcs_pkg::*;

  logic take;

  always_comb begin
    mode_o  = mode_i;
    rem_o   = rem_i;
    expired = 1'b0;
    take    = 1'b0;
    unique case (mode_i)
      MODE_ARMED: begin
        mode_o = MODE_RUNNING;
        rem_o  = rel_i;
        take   = 1'b1;
      end
      MODE_RUNNING: begin
        take = 1'b1;
        if (elapsed >= rem_i) begin
          expired = 1'b1;
          rem_o   = rel_i;
        end else begin
          rem_o = rem_i - elapsed;
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase
    next_o = (take && (rem_o < next_i)) ? rem_o : next_i;
  end

endmodule

### rtl/multi_timer_compare_scheduler_core.sv
// Multiplexes NUM_SLOTS periodic timers onto one compare counter. Slots sit in a
// ring of cells; a scheduling pass (compare event or start) rotates the ring
// once through a single slot processor, one slot per cycle in index order
// while the output side does not stall an expiry, and posts one item per
// expired slot followed by a final item carrying the next compare value, which
// waits while the output side stalls. Stop and suspend only rewrite the mode
// of the selected slot and start no pass. A new item is taken only between
// passes, while the last result may still wait at the output register.
module multi_timer_compare_scheduler_core #(
  parameter int NUM_SLOTS   = mtcs_pkg::DEF_NUM_SLOTS,
  parameter int COUNT_WIDTH = mtcs_pkg::DEF_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mtcs_pkg::TICK_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtcs_pkg::FUNC_W-1:0]  in_func,
  input  logic [mtcs_pkg::INDEX_W-1:0] in_timer_index,
  input  logic [mtcs_pkg::TICK_W-1:0]  in_load_ticks,
  input  logic [mtcs_pkg::TICK_W-1:0]  in_elapsed_ticks,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [mtcs_pkg::INDEX_W-1:0] out_expired_index,
  output logic [mtcs_pkg::TICK_W-1:0]  out_next_compare,
  output logic                         out_last
);
  import mtcs_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TICK_W-1:0]      idle_cmp_r;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] next_r, next_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [INDEX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [TICK_W-1:0]      out_cmp_r, out_cmp_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [MODE_W-1:0]      c_mode [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] c_rem  [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] c_rel  [NUM_SLOTS];

  logic [MODE_W-1:0]      p_mode;
  logic [COUNT_WIDTH-1:0] p_rem;
  logic                   p_exp;
  logic [COUNT_WIDTH-1:0] p_next;

  logic                   accept, can_load, step, wr_any, is_start;
  logic [MODE_W-1:0]      wr_mode_val;
  logic [COUNT_WIDTH-1:0] load_c;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign step     = (state_r == ST_PASS) && (!p_exp || can_load);
  assign is_start = accept && (in_func == FUNC_START);
  assign wr_any   = accept && (in_func != FUNC_PASS);
  assign load_c   = COUNT_WIDTH'(in_load_ticks);

  always_comb begin
    unique case (in_func)
      FUNC_START:   wr_mode_val = MODE_ARMED;
      FUNC_STOP:    wr_mode_val = MODE_IDLE;
      FUNC_SUSPEND: wr_mode_val = MODE_SUSPENDED;
      default:      wr_mode_val = MODE_IDLE;
    endcase
  end

  mtcs_slot_proc #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_proc (
    .mode_i  (c_mode[0]),
    .rem_i   (c_rem[0]),
    .rel_i   (c_rel[0]),
    .elapsed (elapsed_r),
    .next_i  (next_r),
    .mode_o  (p_mode),
    .rem_o   (p_rem),
    .expired (p_exp),
    .next_o  (p_next)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
    cell_ctrl_t             ctrl;
    logic                   sel;
    logic [MODE_W-1:0]      sh_mode;
    logic [COUNT_WIDTH-1:0] sh_rem;
    logic [COUNT_WIDTH-1:0] sh_rel;

    assign sel            = (32'(in_timer_index) == i);
    assign ctrl.shift     = step;
    assign ctrl.wr_mode   = wr_any && sel;
    assign ctrl.wr_counts = is_start && sel;

    if (i == NUM_SLOTS - 1) begin : g_tail
      assign sh_mode = p_mode;
      assign sh_rem  = p_rem;
      assign sh_rel  = c_rel[0];
    end else begin : g_body
      assign sh_mode = c_mode[i+1];
      assign sh_rem  = c_rem[i+1];
      assign sh_rel  = c_rel[i+1];
    end

    mtcs_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .wr_mode  (wr_mode_val),
      .wr_count (load_c),
      .sh_mode  (sh_mode),
      .sh_rem   (sh_rem),
      .sh_rel   (sh_rel),
      .mode     (c_mode[i]),
      .rem      (c_rem[i]),
      .rel      (c_rel[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    elapsed_nxt   = elapsed_r;
    next_nxt      = next_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_cmp_nxt   = out_cmp_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_PASS || in_func == FUNC_START)) begin
          state_nxt   = ST_PASS;
          idx_nxt     = '0;
          elapsed_nxt = COUNT_WIDTH'(in_elapsed_ticks);
          next_nxt    = COUNT_WIDTH'(idle_cmp_r);
        end
      end
      ST_PASS: begin
        if (step) begin
          next_nxt = p_next;
          idx_nxt  = idx_r + 1'b1;
          if (p_exp) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_idx_nxt   = INDEX_W'(idx_r);
            out_cmp_nxt   = '0;
            out_last_nxt  = 1'b0;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_idx_nxt   = '0;
          out_cmp_nxt   = TICK_W'(next_r);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      idle_cmp_r  <= '1;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        idle_cmp_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r  <= elapsed_nxt;
    next_r     <= next_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cmp_r  <= out_cmp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_expired_index = out_idx_r;
  assign out_next_compare  = out_cmp_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == FUNC_PASS || in_func == FUNC_START) |=> state_r == ST_PASS)
    else $error("pass did not start after accepted item");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last flag disagrees with result kind");

  a_ring_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) && !step |=> $stable(idx_r) && $stable(next_r))
    else $error("ring advanced while output stalled");

  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && (idx_r == IDX_LAST) |=> state_r == ST_FIN)
    else $error("pass did not finish after last slot");
`endif

endmodule
